>>> rtl/core/mf3_pkg.sv
// Shared types, constants and compare-exchange functions for the 3x3 median filter.
`default_nettype none

package mf3_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int MIN_SIZE   = 3;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int COORD_W    = 11;
    localparam int CFG_W      = 12;
    localparam int PIX_W      = 8;
    localparam int NCH        = 3;
    localparam int CELL_W     = PIX_W * NCH;
    localparam int WIN_N      = 9;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    typedef enum logic [1:0] {
        REG_LINE_WIDTH   = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_COLOR_MODE   = 2'd2
    } t_reg;

    typedef logic [PIX_W-1:0]  t_pel;
    typedef t_pel [WIN_N-1:0]  t_nine;
    typedef logic [CELL_W-1:0] t_cell;
    typedef t_cell [WIN_N-1:0] t_win;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_c0;
        logic [PIX_W-1:0] pixel_c1;
        logic [PIX_W-1:0] pixel_c2;
    } t_pix;

    typedef struct packed {
        logic [PIX_W-1:0]   median_c0;
        logic [PIX_W-1:0]   median_c1;
        logic [PIX_W-1:0]   median_c2;
        logic [COORD_W-1:0] out_column;
        logic [COORD_W-1:0] out_row;
        logic               frame_last;
    } t_res;

    typedef struct packed {
        logic               color_mode;
        logic [COL_W-1:0]   last_col;
        logic [ROW_W-1:0]   last_row;
    } t_cfg;

    typedef struct packed {
        logic               color_mode;
        logic               frame_last;
        logic [COORD_W-1:0] out_column;
        logic [COORD_W-1:0] out_row;
    } t_tag;

    typedef struct packed {
        t_tag tag;
        t_win win;
    } t_job;

    function automatic logic [COL_W-1:0] last_col(input logic [CFG_W-1:0] v);
        logic [COL_W-1:0] r;
        if (v < CFG_W'(MIN_SIZE)) begin
            r = COL_W'(MIN_SIZE - 1);
        end else if (32'(v) > 32'(MAX_WIDTH)) begin
            r = COL_W'(MAX_WIDTH - 1);
        end else begin
            r = COL_W'(v - CFG_W'(1));
        end
        return r;
    endfunction

    function automatic logic [ROW_W-1:0] last_row(input logic [CFG_W-1:0] v);
        logic [ROW_W-1:0] r;
        if (v < CFG_W'(MIN_SIZE)) begin
            r = ROW_W'(MIN_SIZE - 1);
        end else if (32'(v) > 32'(MAX_HEIGHT)) begin
            r = ROW_W'(MAX_HEIGHT - 1);
        end else begin
            r = ROW_W'(v - CFG_W'(1));
        end
        return r;
    endfunction

    function automatic t_nine cx(input t_nine v, input int unsigned a, input int unsigned b);
        t_nine r;
        r = v;
        if (v[a] > v[b]) begin
            r[a] = v[b];
            r[b] = v[a];
        end
        return r;
    endfunction

    function automatic t_nine med_a(input t_nine v);
        t_nine t;
        t = v;
        t = cx(t, 1, 2); t = cx(t, 4, 5); t = cx(t, 7, 8);
        t = cx(t, 0, 1); t = cx(t, 3, 4); t = cx(t, 6, 7);
        t = cx(t, 1, 2); t = cx(t, 4, 5); t = cx(t, 7, 8);
        return t;
    endfunction

    function automatic t_nine med_b(input t_nine v);
        t_nine t;
        t = v;
        t = cx(t, 0, 3); t = cx(t, 5, 8); t = cx(t, 4, 7);
        t = cx(t, 3, 6); t = cx(t, 1, 4); t = cx(t, 2, 5);
        t = cx(t, 4, 7);
        return t;
    endfunction

    function automatic t_pel med_c(input t_nine v);
        t_nine t;
        t = v;
        t = cx(t, 4, 2);
        t = cx(t, 6, 4);
        t = cx(t, 4, 2);
        return t[4];
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/mf3_front.sv
// Front part: pixel counters, line store, 3x3 window and result classification.
`default_nettype none

module mf3_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire mf3_pkg::t_pix                 i_pix,
    input  wire mf3_pkg::t_cfg                 i_cfg,
    input  wire logic [mf3_pkg::QCNT_W-1:0]    i_q_count,
    output logic                               o_push,
    output mf3_pkg::t_job                      o_job
);
    import mf3_pkg::*;

    logic [COL_W-1:0]    r_col, n_col;
    logic [ROW_W-1:0]    r_row, n_row;
    logic                w_accept;
    logic                w_emit;
    logic                w_last;
    logic [QCNT_W:0]     w_load;

    logic                r_a_vld;
    logic                r_a_emit;
    logic                r_a_last;
    logic [COL_W-1:0]    r_a_col;
    logic [ROW_W-1:0]    r_a_row;
    t_cell               r_a_pix;

    logic [2*CELL_W-1:0] r_mem [MAX_WIDTH];
    logic [2*CELL_W-1:0] r_rd;
    t_win                r_win, n_win;

    assign w_load   = {1'b0, i_q_count} + {{QCNT_W{1'b0}}, r_a_vld};
    assign o_stall  = w_load >= (QCNT_W + 1)'(QDEPTH);
    assign w_accept = i_valid && !o_stall;

    assign w_emit = (r_col >= COL_W'(2)) && (r_row >= ROW_W'(2))
                 && (r_col <= i_cfg.last_col) && (r_row <= i_cfg.last_row);
    assign w_last = (r_col == i_cfg.last_col) && (r_row == i_cfg.last_row);

    always_comb begin
        n_col = r_col + COL_W'(1);
        n_row = r_row;
        if (r_col >= i_cfg.last_col) begin
            n_col = '0;
            n_row = (r_row >= i_cfg.last_row) ? '0 : r_row + ROW_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= w_accept;
            if (w_accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a_emit <= w_emit;
            r_a_last <= w_last;
            r_a_col  <= r_col;
            r_a_row  <= r_row;
            r_a_pix  <= {i_pix.pixel_c2, i_pix.pixel_c1, i_pix.pixel_c0};
        end
    end

    // Each entry holds the middle row in the upper half and the upper row in the lower half.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd <= r_mem[r_col];
        end
        if (r_a_vld) begin
            r_mem[r_a_col] <= {r_a_pix, r_rd[2*CELL_W-1:CELL_W]};
        end
    end

    always_comb begin
        n_win = r_win;
        for (int r = 0; r < 3; r++) begin
            n_win[r*3]     = r_win[r*3 + 1];
            n_win[r*3 + 1] = r_win[r*3 + 2];
        end
        n_win[2] = r_rd[CELL_W-1:0];
        n_win[5] = r_rd[2*CELL_W-1:CELL_W];
        n_win[8] = r_a_pix;
    end

    always_ff @(posedge i_clk) begin
        if (r_a_vld) begin
            r_win <= n_win;
        end
    end

    assign o_push              = r_a_vld && r_a_emit;
    assign o_job.tag.color_mode = i_cfg.color_mode;
    assign o_job.tag.frame_last = r_a_last;
    assign o_job.tag.out_column = COORD_W'(r_a_col - COL_W'(1));
    assign o_job.tag.out_row    = COORD_W'(r_a_row - ROW_W'(1));
    assign o_job.win            = n_win;

endmodule

`default_nettype wire

>>> rtl/core/mf3_queue.sv
// Short queue of complete windows between the front and back parts.
`default_nettype none

module mf3_queue (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_push,
    input  wire mf3_pkg::t_job               i_job,
    input  wire logic                        i_pop,
    output logic                             o_valid,
    output mf3_pkg::t_job                    o_job,
    output logic [mf3_pkg::QCNT_W-1:0]       o_count
);
    import mf3_pkg::*;

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_pop;

    assign o_valid = r_count != '0;
    assign o_job   = r_mem[r_rd_ptr];
    assign o_count = r_count;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !w_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (!i_push && w_pop) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/mf3_back.sv
// Back part: three-stage compare-exchange pipeline ending in the output register.
`default_nettype none

module mf3_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_q_valid,
    input  wire mf3_pkg::t_job      i_job,
    output logic                    o_pop,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output mf3_pkg::t_res           o_res
);
    import mf3_pkg::*;

    logic             w_en;
    t_nine [NCH-1:0]  w_ch;
    t_nine [NCH-1:0]  r_s1_ch;
    t_nine [NCH-1:0]  r_s2_ch;
    t_tag             r_s1_tag;
    t_tag             r_s2_tag;
    logic             r_v1;
    logic             r_v2;
    logic             r_v3;
    t_res             r_res;

    assign w_en  = !r_v3 || !i_stall;
    assign o_pop = w_en && i_q_valid;

    always_comb begin
        for (int k = 0; k < NCH; k++) begin
            for (int i = 0; i < WIN_N; i++) begin
                w_ch[k][i] = i_job.win[i][k*PIX_W +: PIX_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_q_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < NCH; k++) begin
                r_s1_ch[k] <= med_a(w_ch[k]);
                r_s2_ch[k] <= med_b(r_s1_ch[k]);
            end
            r_s1_tag <= i_job.tag;
            r_s2_tag <= r_s1_tag;
            r_res.median_c0  <= med_c(r_s2_ch[0]);
            r_res.median_c1  <= r_s2_tag.color_mode ? med_c(r_s2_ch[1]) : '0;
            r_res.median_c2  <= r_s2_tag.color_mode ? med_c(r_s2_ch[2]) : '0;
            r_res.out_column <= r_s2_tag.out_column;
            r_res.out_row    <= r_s2_tag.out_row;
            r_res.frame_last <= r_s2_tag.frame_last;
        end
    end

    assign o_valid = r_v3;
    assign o_res   = r_res;

endmodule

`default_nettype wire

>>> rtl/core/median_filter_3x3_unit.sv
// Top level of the 3x3 median filter with its configuration registers.
// Accepts one pixel per clock cycle in raster order while o_in_stall is low and
// returns the per-channel median of the 3x3 neighborhood for every interior pixel.
// The rate is set by the single line store, a 2048 x 48 memory that is read and
// written once per accepted pixel; the median network is spread over three pipeline
// stages and never limits it.
// A four-entry queue parts the window builder from the median pipeline, so input
// stalls only when results back up at the output. The line store has no clearing
// pass: its rows are valid once the first two rows of a frame have passed.
// Registers at byte addresses 0, 4 and 8: line width, frame height, color mode.
`default_nettype none

module median_filter_3x3_unit (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire mf3_pkg::t_pix                i_in_data,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output mf3_pkg::t_res                     o_out_data,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [mf3_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [mf3_pkg::DATA_W-1:0]   pwdata,
    output logic [mf3_pkg::DATA_W-1:0]        prdata,
    output logic                              pready
);
    import mf3_pkg::*;

    logic [CFG_W-1:0]  r_line_width;
    logic [CFG_W-1:0]  r_frame_height;
    logic              r_color_mode;
    t_reg              w_reg;
    t_cfg              w_cfg;

    logic              w_push;
    t_job              w_push_job;
    logic              w_q_valid;
    t_job              w_q_job;
    logic [QCNT_W-1:0] w_q_count;
    logic              w_pop;

    assign pready = 1'b1;
    assign w_reg  = t_reg'(paddr[ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width   <= CFG_W'(640);
            r_frame_height <= CFG_W'(480);
            r_color_mode   <= 1'b1;
        end else if (psel && penable && pwrite) begin
            case (w_reg)
                REG_LINE_WIDTH: begin
                    r_line_width <= pwdata[CFG_W-1:0];
                end
                REG_FRAME_HEIGHT: begin
                    r_frame_height <= pwdata[CFG_W-1:0];
                end
                REG_COLOR_MODE: begin
                    r_color_mode <= pwdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            REG_LINE_WIDTH:   prdata = DATA_W'(r_line_width);
            REG_FRAME_HEIGHT: prdata = DATA_W'(r_frame_height);
            REG_COLOR_MODE:   prdata = DATA_W'(r_color_mode);
            default:          prdata = '0;
        endcase
    end

    assign w_cfg.color_mode = r_color_mode;
    assign w_cfg.last_col   = last_col(r_line_width);
    assign w_cfg.last_row   = last_row(r_frame_height);

    mf3_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_pix     (i_in_data),
        .i_cfg     (w_cfg),
        .i_q_count (w_q_count),
        .o_push    (w_push),
        .o_job     (w_push_job)
    );

    mf3_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_job   (w_q_job),
        .o_count (w_q_count)
    );

    mf3_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_job     (w_q_job),
        .o_pop     (w_pop),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_res     (o_out_data)
    );

endmodule

`default_nettype wire

>>> rtl/core/mf3_check.sv
// Port-level checks for the 3x3 median filter and their attachment to the top level.
`default_nettype none

module mf3_check (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           o_in_stall,
    input  wire logic           o_out_valid,
    input  wire logic           i_out_stall,
    input  wire mf3_pkg::t_res  o_out_data
);
    import mf3_pkg::*;

    a_out_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("A result was shown right after reset.");

    a_in_open_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("The input stalled right after reset.");

    a_interior_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.out_column != '0) && (o_out_data.out_row != '0))
        else $error("A result was given for a border pixel.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("A stalled result changed or was dropped.");

endmodule

bind median_filter_3x3_unit mf3_check u_mf3_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire
